// File: sv/bounded_event_queue_core_defines.svh
// ----------------------------------------------------------------------------
// Bounded event queue: assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_EVENT_QUEUE_CORE_DEFINES_SVH
`define BOUNDED_EVENT_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication.
`define BEQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BEQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/beq_pkg.sv
// ----------------------------------------------------------------------------
// Bounded event queue package
// Sizes, codes, entry layout and control structs shared by the queue files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package beq_pkg;

  // Storage sizes
  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned SEQ_BITS    = 32;

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int unsigned LIM_W      = 7;
  localparam int unsigned BYTE_W     = 20;
  localparam int unsigned KIND_W     = 4;
  localparam int unsigned PEER_W     = 16;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned OUT_SEQ_W  = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

  localparam logic [LIM_W-1:0]  COUNT_LIMIT_RST = LIM_W'(64);
  localparam logic [BYTE_W-1:0] BYTE_LIMIT_RST  = BYTE_W'(65536);

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POLL   = 2'd1,
    OP_FINISH = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_READY     = 2'd0,
    ST_TIMEOUT   = 2'd1,
    ST_STOPPED   = 2'd2,
    ST_TOO_SMALL = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNT_LIMIT = 1'b0,
    CFG_BYTE_LIMIT  = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_POLL = 1'b1
  } state_e;

  // One queued descriptor, one memory word.
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [PEER_W-1:0]   peer;
    logic [SEQ_BITS-1:0] seq;
    logic [LEN_W-1:0]    len;
  } entry_t;

  // Ring pointer commands, at most one active per cycle.
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } ring_ctrl_t;

  function automatic logic [OUT_SEQ_W-1:0] seq_to_out(input logic [SEQ_BITS-1:0] s);
    logic [63:0] w;
    w = 64'(s);
    return w[OUT_SEQ_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: sv/bounded_event_queue_core.sv
// ----------------------------------------------------------------------------
// Bounded event queue core
// Event descriptor FIFO bounded by entry count and by total payload bytes.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                      Payload
//  --------  -----------------------------  --------------------------------------
//  command   start & !busy                  operation_i, event_kind_i, peer_id_i,
//                                           payload_length_i, capacity_i
//  result    done_o (one-cycle strobe)      push_accepted_o .. overflowed_o
//  config    cfg_we_i                       cfg_idx_i, cfg_wdata_i
//
//  Push, finish and no-op: result strobes in the cycle after acceptance.
//  Poll: acceptance moves the FSM to S_POLL, which waits on the registered
//  read of the head entry from the descriptor memory; busy is high in S_POLL,
//  and the result is registered from S_POLL onto the ports.
//  Reset clears pointers, counters and flags; no memory clearing pass.
//  Results cannot be stalled; a new transaction may be accepted while the
//  previous result is on the ports.
//
`timescale 1ns / 1ps
`default_nettype none

`include "bounded_event_queue_core_defines.svh"

module bounded_event_queue_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,

  // config write port
  input  wire logic                             cfg_we_i,
  input  wire logic [beq_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [beq_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,

  // command transaction
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       operation_i,
  input  wire logic [beq_pkg::KIND_W-1:0]       event_kind_i,
  input  wire logic [beq_pkg::PEER_W-1:0]       peer_id_i,
  input  wire logic [beq_pkg::LEN_W-1:0]        payload_length_i,
  input  wire logic [beq_pkg::LEN_W-1:0]        capacity_i,

  // result transaction
  output logic                                  done_o,
  output logic                                  push_accepted_o,
  output logic [1:0]                            poll_status_o,
  output logic [beq_pkg::KIND_W-1:0]            out_kind_o,
  output logic                                  is_overflow_event_o,
  output logic [beq_pkg::PEER_W-1:0]            out_peer_o,
  output logic [beq_pkg::OUT_SEQ_W-1:0]         out_sequence_o,
  output logic [beq_pkg::LEN_W-1:0]             out_length_o,
  output logic                                  overflowed_o
);

  localparam int unsigned CmpW = (beq_pkg::CNT_W > beq_pkg::LIM_W) ?
                                 beq_pkg::CNT_W : beq_pkg::LIM_W;

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  logic [beq_pkg::LIM_W-1:0]  count_limit_q;
  logic [beq_pkg::BYTE_W-1:0] byte_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_limit_q <= beq_pkg::COUNT_LIMIT_RST;
      byte_limit_q  <= beq_pkg::BYTE_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (beq_pkg::cfg_idx_e'(cfg_idx_i))
        beq_pkg::CFG_COUNT_LIMIT: count_limit_q <= cfg_wdata_i[beq_pkg::LIM_W-1:0];
        beq_pkg::CFG_BYTE_LIMIT:  byte_limit_q  <= cfg_wdata_i[beq_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  beq_pkg::state_e state_q, state_d;

  logic [beq_pkg::BYTE_W-1:0]   byte_total_q, byte_total_d;
  logic [beq_pkg::SEQ_BITS-1:0] next_seq_q, next_seq_d;
  logic                         stopped_q, stopped_d;
  logic                         ovf_q, ovf_d;
  logic                         ovf_told_q, ovf_told_d;
  logic [beq_pkg::LEN_W-1:0]    cap_q, cap_d;

  // Result registers
  logic                          done_q, done_d;
  logic                          acc_q, acc_d;
  beq_pkg::status_e              status_q, status_d;
  logic [beq_pkg::KIND_W-1:0]    kind_q, kind_d;
  logic                          ovf_evt_q, ovf_evt_d;
  logic [beq_pkg::PEER_W-1:0]    peer_q, peer_d;
  logic [beq_pkg::OUT_SEQ_W-1:0] seq_q, seq_d;
  logic [beq_pkg::LEN_W-1:0]     len_q, len_d;
  logic                          ovfl_q, ovfl_d;

  // Ring interface
  beq_pkg::ring_ctrl_t       ring_ctrl;
  beq_pkg::entry_t           ring_wdata;
  beq_pkg::entry_t           ring_rdata;
  logic [beq_pkg::CNT_W-1:0] ring_count;

  beq_ring u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ring_ctrl),
    .wdata_i (ring_wdata),
    .rdata_o (ring_rdata),
    .count_o (ring_count)
  );

  logic            accept;
  beq_pkg::op_e    op;
  logic            limit_hit;
  logic [beq_pkg::BYTE_W:0] byte_sum;

  assign op     = beq_pkg::op_e'(operation_i);
  assign accept = start && !busy;

  // Push limit check: count limit, ring depth, and bytes (sum covers limit < total).
  assign byte_sum  = {1'b0, byte_total_q} + (beq_pkg::BYTE_W + 1)'(payload_length_i);
  assign limit_hit = (CmpW'(ring_count) >= CmpW'(count_limit_q))
                  || (ring_count == beq_pkg::CNT_FULL)
                  || (byte_sum > {1'b0, byte_limit_q});

  assign ring_wdata = '{kind: event_kind_i, peer: peer_id_i, seq: next_seq_q,
                        len: payload_length_i};

  // --------------------------------------------------------------------------
  // FSM: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      beq_pkg::S_IDLE: begin
        if (accept && op == beq_pkg::OP_POLL) begin
          state_d = beq_pkg::S_POLL;
        end
      end
      beq_pkg::S_POLL: state_d = beq_pkg::S_IDLE;
      default:         state_d = beq_pkg::S_IDLE;
    endcase
  end

  // FSM: outputs
  always_comb begin
    case (state_q)
      beq_pkg::S_IDLE: busy = 1'b0;
      beq_pkg::S_POLL: busy = 1'b1;
      default:         busy = 1'b1;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath: read-modify-write of counters and ring
  // --------------------------------------------------------------------------
  always_comb begin
    byte_total_d = byte_total_q;
    next_seq_d   = next_seq_q;
    stopped_d    = stopped_q;
    ovf_d        = ovf_q;
    ovf_told_d   = ovf_told_q;
    cap_d        = cap_q;
    ring_ctrl    = '0;

    done_d    = 1'b0;
    acc_d     = 1'b0;
    status_d  = beq_pkg::ST_READY;
    kind_d    = '0;
    ovf_evt_d = 1'b0;
    peer_d    = '0;
    seq_d     = '0;
    len_d     = '0;

    if (accept) begin
      case (op)
        beq_pkg::OP_PUSH: begin
          done_d = 1'b1;
          if (!stopped_q && !ovf_q) begin
            if (limit_hit) begin
              // overflow drops the whole queue
              ovf_d           = 1'b1;
              ring_ctrl.clear = 1'b1;
              byte_total_d    = '0;
            end else begin
              ring_ctrl.push = 1'b1;
              byte_total_d   = byte_sum[beq_pkg::BYTE_W-1:0];
              next_seq_d     = next_seq_q + 1'b1;
              acc_d          = 1'b1;
            end
          end
        end
        beq_pkg::OP_POLL:   cap_d = capacity_i;
        beq_pkg::OP_FINISH: begin
          done_d    = 1'b1;
          stopped_d = 1'b1;
        end
        default: done_d = 1'b1;
      endcase
    end

    // Poll completes once the head word is out of the memory.
    if (state_q == beq_pkg::S_POLL) begin
      done_d = 1'b1;
      if (ovf_q) begin
        if (ovf_told_q) begin
          status_d = beq_pkg::ST_STOPPED;
        end else begin
          ovf_evt_d  = 1'b1;
          seq_d      = beq_pkg::seq_to_out(next_seq_q);
          next_seq_d = next_seq_q + 1'b1;
          ovf_told_d = 1'b1;
        end
      end else if (ring_count == '0) begin
        status_d = stopped_q ? beq_pkg::ST_STOPPED : beq_pkg::ST_TIMEOUT;
      end else begin
        kind_d = ring_rdata.kind;
        peer_d = ring_rdata.peer;
        seq_d  = beq_pkg::seq_to_out(ring_rdata.seq);
        len_d  = ring_rdata.len;
        if (ring_rdata.len > cap_q) begin
          status_d = beq_pkg::ST_TOO_SMALL;
        end else begin
          ring_ctrl.pop = 1'b1;
          byte_total_d  = byte_total_q - beq_pkg::BYTE_W'(ring_rdata.len);
        end
      end
    end

    ovfl_d = ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= beq_pkg::S_IDLE;
      byte_total_q <= '0;
      next_seq_q   <= '0;
      stopped_q    <= 1'b0;
      ovf_q        <= 1'b0;
      ovf_told_q   <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      byte_total_q <= byte_total_d;
      next_seq_q   <= next_seq_d;
      stopped_q    <= stopped_d;
      ovf_q        <= ovf_d;
      ovf_told_q   <= ovf_told_d;
      done_q       <= done_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    cap_q     <= cap_d;
    acc_q     <= acc_d;
    status_q  <= status_d;
    kind_q    <= kind_d;
    ovf_evt_q <= ovf_evt_d;
    peer_q    <= peer_d;
    seq_q     <= seq_d;
    len_q     <= len_d;
    ovfl_q    <= ovfl_d;
  end

  assign done_o              = done_q;
  assign push_accepted_o     = acc_q;
  assign poll_status_o       = status_q;
  assign out_kind_o          = kind_q;
  assign is_overflow_event_o = ovf_evt_q;
  assign out_peer_o          = peer_q;
  assign out_sequence_o      = seq_q;
  assign out_length_o        = len_q;
  assign overflowed_o        = ovfl_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BEQ_ASSERT_NXT(a_fast_done, accept && op != beq_pkg::OP_POLL, done_o && !busy, "missing result")
  `BEQ_ASSERT_NXT(a_poll_done, state_q == beq_pkg::S_POLL, done_o && !busy, "missing poll result")
  `BEQ_ASSERT_IMP(a_ovf_evt, done_o && is_overflow_event_o, overflowed_o && poll_status_o == beq_pkg::ST_READY, "overflow event without flag")
  `BEQ_ASSERT_IMP(a_push_clean, done_o && push_accepted_o, !overflowed_o && poll_status_o == beq_pkg::ST_READY, "push accepted while overflowed")

endmodule

`default_nettype wire

// File: sv/beq_ring.sv
// ----------------------------------------------------------------------------
// Bounded event queue ring
// Descriptor memory with head/tail pointers and occupancy count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bounded_event_queue_core_defines.svh"

module beq_ring (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire beq_pkg::ring_ctrl_t       ctrl_i,
  input  wire beq_pkg::entry_t           wdata_i,
  output beq_pkg::entry_t                rdata_o,
  output logic [beq_pkg::CNT_W-1:0]      count_o
);

  beq_pkg::entry_t mem [beq_pkg::QUEUE_DEPTH];
  beq_pkg::entry_t rdata_q;

  logic [beq_pkg::IDX_W-1:0] head_q, head_d;
  logic [beq_pkg::IDX_W-1:0] tail_q, tail_d;
  logic [beq_pkg::CNT_W-1:0] count_q, count_d;

  function automatic logic [beq_pkg::IDX_W-1:0] wrap_inc(input logic [beq_pkg::IDX_W-1:0] p);
    return (p == beq_pkg::IDX_LAST) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctrl_i.clear) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end else if (ctrl_i.push) begin
      tail_d  = wrap_inc(tail_q);
      count_d = count_q + 1'b1;
    end else if (ctrl_i.pop) begin
      head_d  = wrap_inc(head_q);
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Head is read every cycle; a poll holds the pointers until it uses the word.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && !ctrl_i.clear) begin
      mem[tail_q] <= wdata_i;
    end
    rdata_q <= mem[head_q];
  end

  assign rdata_o = rdata_q;
  assign count_o = count_q;

  `BEQ_ASSERT_IMP(a_empty_ptrs, count_q == '0, head_q == tail_q, "empty ring with split pointers")
  `BEQ_ASSERT_IMP(a_no_underflow, ctrl_i.pop, count_q != '0, "pop from empty ring")
  `BEQ_ASSERT_IMP(a_no_overfill, ctrl_i.push, count_q != beq_pkg::CNT_FULL, "push into full ring")

endmodule

`default_nettype wire
